/* rtl/ceb_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ceb_pkg
// shared constants and types for the cubic bezier easing pipeline
// ----------------------------------------------------------------------------
package ceb_pkg;

  localparam int SOLVE_STEPS_DEF   = 16;
  localparam int FRACTION_BITS_DEF = 15;

  localparam int TIME_W  = 16;
  localparam int VALUE_W = 16;
  localparam int IN_W    = 17;

  localparam logic [TIME_W-1:0] TIME_ONE = 16'd32768;

  typedef enum logic [1:0] {
    REG_FIRST_X  = 2'd0,
    REG_FIRST_Y  = 2'd1,
    REG_SECOND_X = 2'd2,
    REG_SECOND_Y = 2'd3
  } reg_idx_t;

  localparam logic [VALUE_W-1:0] RST_FIRST_X  = 16'd8192;
  localparam logic [VALUE_W-1:0] RST_FIRST_Y  = 16'd1638;
  localparam logic [VALUE_W-1:0] RST_SECOND_X = 16'd8192;
  localparam logic [VALUE_W-1:0] RST_SECOND_Y = 16'd16384;

endpackage

/* rtl/ceb_basis.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ceb_basis
// two-stage bernstein basis: (1-t)^2 t, (1-t) t^2, t^3 in truncated fixed point
// ----------------------------------------------------------------------------
module ceb_basis #(
  parameter int FRACTION_BITS = ceb_pkg::FRACTION_BITS_DEF,
  parameter int PW            = 1
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  logic                   in_valid,
  input  logic [FRACTION_BITS:0] t,
  input  logic [PW-1:0]          pl_in,
  output logic                   out_valid,
  output logic [FRACTION_BITS:0] uut,
  output logic [FRACTION_BITS:0] utt,
  output logic [FRACTION_BITS:0] ttt,
  output logic [PW-1:0]          pl_out
);

  localparam int F  = FRACTION_BITS;
  localparam int TW = F + 1;
  localparam logic [TW-1:0] ONE = {1'b1, {F{1'b0}}};

  logic [TW-1:0]   u;
  logic [2*TW-1:0] sq_u, sq_t;
  logic [TW-1:0]   t1, u1, uu1, tt1;
  logic [PW-1:0]   pl1;
  logic            v1;
  logic [2*TW-1:0] m_uut, m_utt, m_ttt;

  always_comb begin
    u     = ONE - t;
    sq_u  = u * u;
    sq_t  = t * t;
    m_uut = uu1 * t1;
    m_utt = u1 * tt1;
    m_ttt = tt1 * t1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1        <= in_valid;
      out_valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t1     <= t;
      u1     <= u;
      uu1    <= sq_u[2*F:F];
      tt1    <= sq_t[2*F:F];
      pl1    <= pl_in;
      uut    <= m_uut[2*F:F];
      utt    <= m_utt[2*F:F];
      ttt    <= m_ttt[2*F:F];
      pl_out <= pl1;
    end
  end

endmodule

/* rtl/ceb_step.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ceb_step
// one bisection round: basis at the midpoint, x(mid) against the time, narrow
// ----------------------------------------------------------------------------
module ceb_step #(
  parameter int FRACTION_BITS = ceb_pkg::FRACTION_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic [ceb_pkg::TIME_W-1:0]  x1,
  input  logic [ceb_pkg::TIME_W-1:0]  x2,
  input  logic                        in_valid,
  input  logic [FRACTION_BITS:0]      lo_in,
  input  logic [FRACTION_BITS:0]      hi_in,
  input  logic [ceb_pkg::TIME_W-1:0]  tm_in,
  input  logic                        clip_in,
  output logic                        out_valid,
  output logic [FRACTION_BITS:0]      lo_out,
  output logic [FRACTION_BITS:0]      hi_out,
  output logic [ceb_pkg::TIME_W-1:0]  tm_out,
  output logic                        clip_out
);

  localparam int F  = FRACTION_BITS;
  localparam int TW = F + 1;
  localparam int MW = ceb_pkg::TIME_W;
  localparam int PW = 3 * TW + MW + 1;
  localparam int XW = F + 19;

  logic [TW:0]     sum_lh;
  logic [TW-1:0]   mid;
  logic [PW-1:0]   pl_in, pl_b;
  logic            vb;
  logic [TW-1:0]   uut, utt, ttt;
  logic [TW-1:0]   lo_b, hi_b, mid_b;
  logic [MW-1:0]   tm_b;
  logic            clip_b;
  logic [TW+MW-1:0] p1, p2;
  logic [XW-1:0]   p1e, p2e, xv, target;

  always_comb begin
    sum_lh = {1'b0, lo_in} + {1'b0, hi_in};
    mid    = sum_lh[TW:1];
    pl_in  = {lo_in, hi_in, mid, tm_in, clip_in};
  end

  ceb_basis #(.FRACTION_BITS(F), .PW(PW)) u_basis (
    .clk(clk), .rst(rst), .en(en), .in_valid(in_valid), .t(mid), .pl_in(pl_in),
    .out_valid(vb), .uut(uut), .utt(utt), .ttt(ttt), .pl_out(pl_b)
  );

  always_comb begin
    {lo_b, hi_b, mid_b, tm_b, clip_b} = pl_b;
    p1     = uut * x1;
    p2     = utt * x2;
    p1e    = XW'(p1);
    p2e    = XW'(p2);
    xv     = (p1e << 1) + p1e + (p2e << 1) + p2e + (XW'(ttt) << 15);
    target = XW'(tm_b) << F;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vb;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (xv < target) begin
        lo_out <= mid_b;
        hi_out <= hi_b;
      end else begin
        lo_out <= lo_b;
        hi_out <= mid_b;
      end
      tm_out   <= tm_b;
      clip_out <= clip_b;
    end
  end

endmodule

/* rtl/ceb_eval.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ceb_eval
// y(t) from the solved parameter, rounded and saturated to q2.14
// ----------------------------------------------------------------------------
module ceb_eval #(
  parameter int FRACTION_BITS = ceb_pkg::FRACTION_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  logic signed [ceb_pkg::VALUE_W-1:0] y1,
  input  logic signed [ceb_pkg::VALUE_W-1:0] y2,
  input  logic                              in_valid,
  input  logic [FRACTION_BITS:0]            t,
  input  logic                              clip_in,
  output logic                              out_valid,
  output logic signed [ceb_pkg::VALUE_W-1:0] progress,
  output logic                              time_clipped
);

  localparam int F  = FRACTION_BITS;
  localparam int TW = F + 1;
  localparam int VW = ceb_pkg::VALUE_W;
  localparam int YW = F + 21;
  localparam logic signed [YW-1:0] HALF = YW'(1) << (F - 1);
  localparam logic signed [YW-1:0] VMAX = YW'(32767);
  localparam logic signed [YW-1:0] VMIN = -YW'(32768);

  logic                     vb, clip_b;
  logic [TW-1:0]            uut, utt, ttt;
  logic signed [TW+VW:0]    p1, p2;
  logic signed [YW-1:0]     p1e, p2e, yv, sh;

  ceb_basis #(.FRACTION_BITS(F), .PW(1)) u_basis (
    .clk(clk), .rst(rst), .en(en), .in_valid(in_valid), .t(t), .pl_in(clip_in),
    .out_valid(vb), .uut(uut), .utt(utt), .ttt(ttt), .pl_out(clip_b)
  );

  always_comb begin
    p1  = $signed({1'b0, uut}) * y1;
    p2  = $signed({1'b0, utt}) * y2;
    p1e = YW'(p1);
    p2e = YW'(p2);
    yv  = (p1e <<< 1) + p1e + (p2e <<< 1) + p2e + $signed(YW'(ttt) << 14);
    sh  = (yv + HALF) >>> F;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vb;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (sh > VMAX) begin
        progress <= 16'sh7fff;
      end else if (sh < VMIN) begin
        progress <= -16'sh8000;
      end else begin
        progress <= sh[VW-1:0];
      end
      time_clipped <= clip_b;
    end
  end

endmodule

/* rtl/cubic_bezier_easing_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cubic_bezier_easing_top
// cubic bezier easing curve with two configured control points
// ----------------------------------------------------------------------------
// input channel: sample_time (signed q2.15) with in_valid / in_stall; the time
// is clamped to [0,1] and time_clipped marks an item that was clamped.
// output channel: progress (signed q2.14) and time_clipped with out_valid /
// out_stall. one result per item, in order.
// the curve parameter is found by SOLVE_STEPS bisection rounds, each a three
// stage slice (squares, cubes, x compare), followed by a three stage y
// evaluation and an input register; throughput is one item per cycle while
// the output is not stalled. the whole pipeline advances together; while
// out_stall holds a waiting result the pipeline freezes and in_stall is
// raised, nothing is lost or repeated. the user writes control registers via
// cfg_wr_en / cfg_index / cfg_data only while idle; the block does not
// enforce this. reset restores the default curve and empties the pipeline.
// ----------------------------------------------------------------------------
module cubic_bezier_easing_top #(
  parameter int SOLVE_STEPS   = ceb_pkg::SOLVE_STEPS_DEF,
  parameter int FRACTION_BITS = ceb_pkg::FRACTION_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_wr_en,
  input  logic [1:0]                         cfg_index,
  input  logic [ceb_pkg::VALUE_W-1:0]        cfg_data,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [ceb_pkg::IN_W-1:0]    sample_time,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [ceb_pkg::VALUE_W-1:0] progress,
  output logic                               time_clipped
);

  localparam int F  = FRACTION_BITS;
  localparam int TW = F + 1;
  localparam int MW = ceb_pkg::TIME_W;
  localparam logic [TW-1:0] ONE = {1'b1, {F{1'b0}}};

  logic [MW-1:0] x1, x2, x1c, x2c;
  logic signed [ceb_pkg::VALUE_W-1:0] y1, y2;
  logic adv;

  logic          v_c    [SOLVE_STEPS+1];
  logic [TW-1:0] lo_c   [SOLVE_STEPS+1];
  logic [TW-1:0] hi_c   [SOLVE_STEPS+1];
  logic [MW-1:0] tm_c   [SOLVE_STEPS+1];
  logic          clip_c [SOLVE_STEPS+1];

  logic [MW-1:0] tm_next;
  logic          clip_next;
  logic [TW:0]   sum_f;
  logic [TW-1:0] t_fin;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      x1 <= ceb_pkg::RST_FIRST_X;
      y1 <= ceb_pkg::RST_FIRST_Y;
      x2 <= ceb_pkg::RST_SECOND_X;
      y2 <= ceb_pkg::RST_SECOND_Y;
    end else if (cfg_wr_en) begin
      case (ceb_pkg::reg_idx_t'(cfg_index))
        ceb_pkg::REG_FIRST_X:  x1 <= cfg_data;
        ceb_pkg::REG_FIRST_Y:  y1 <= cfg_data;
        ceb_pkg::REG_SECOND_X: x2 <= cfg_data;
        ceb_pkg::REG_SECOND_Y: y2 <= cfg_data;
        default: ;
      endcase
    end
  end

  assign x1c = (x1 > ceb_pkg::TIME_ONE) ? ceb_pkg::TIME_ONE : x1;
  assign x2c = (x2 > ceb_pkg::TIME_ONE) ? ceb_pkg::TIME_ONE : x2;

  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  // input clamp
  always_comb begin
    if (sample_time[ceb_pkg::IN_W-1]) begin
      tm_next   = '0;
      clip_next = 1'b1;
    end else if (sample_time[MW-1:0] > ceb_pkg::TIME_ONE) begin
      tm_next   = ceb_pkg::TIME_ONE;
      clip_next = 1'b1;
    end else begin
      tm_next   = sample_time[MW-1:0];
      clip_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_c[0] <= 1'b0;
    end else if (adv) begin
      v_c[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tm_c[0]   <= tm_next;
      clip_c[0] <= clip_next;
    end
  end

  assign lo_c[0] = '0;
  assign hi_c[0] = ONE;

  for (genvar g = 0; g < SOLVE_STEPS; g++) begin : g_step
    ceb_step #(.FRACTION_BITS(F)) u_step (
      .clk(clk), .rst(rst), .en(adv), .x1(x1c), .x2(x2c),
      .in_valid(v_c[g]), .lo_in(lo_c[g]), .hi_in(hi_c[g]),
      .tm_in(tm_c[g]), .clip_in(clip_c[g]),
      .out_valid(v_c[g+1]), .lo_out(lo_c[g+1]), .hi_out(hi_c[g+1]),
      .tm_out(tm_c[g+1]), .clip_out(clip_c[g+1])
    );
  end

  always_comb begin
    sum_f = {1'b0, lo_c[SOLVE_STEPS]} + {1'b0, hi_c[SOLVE_STEPS]};
    if (tm_c[SOLVE_STEPS] == '0) begin
      t_fin = '0;
    end else if (tm_c[SOLVE_STEPS] == ceb_pkg::TIME_ONE) begin
      t_fin = ONE;
    end else begin
      t_fin = sum_f[TW:1];
    end
  end

  ceb_eval #(.FRACTION_BITS(F)) u_eval (
    .clk(clk), .rst(rst), .en(adv), .y1(y1), .y2(y2),
    .in_valid(v_c[SOLVE_STEPS]), .t(t_fin), .clip_in(clip_c[SOLVE_STEPS]),
    .out_valid(out_valid), .progress(progress), .time_clipped(time_clipped)
  );

endmodule

/* rtl/ceb_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ceb_checker
// port-level checks for the easing pipeline
// ----------------------------------------------------------------------------
module ceb_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               in_stall,
  input logic                               out_valid,
  input logic                               out_stall,
  input logic signed [ceb_pkg::VALUE_W-1:0] progress,
  input logic                               time_clipped
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(progress) && $stable(time_clipped))
    else $error("stalled result changed");

  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    in_stall == (out_valid && out_stall))
    else $error("input stall does not follow output stall");

  a_no_stall_idle: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall)
    else $error("input stalled with no waiting item");

endmodule

bind cubic_bezier_easing_top ceb_checker u_ceb_checker (
  .clk(clk), .rst(rst), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .progress(progress),
  .time_clipped(time_clipped)
);

/* tb/ceb_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ceb_scoreboard
// watches both channels, predicts the eased value of every accepted item and
// compares each result with the oldest pending prediction
// ----------------------------------------------------------------------------
module ceb_scoreboard (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_wr_en,
  input  logic [1:0]                         cfg_index,
  input  logic [ceb_pkg::VALUE_W-1:0]        cfg_data,
  input  logic                               in_valid,
  input  logic                               in_stall,
  input  logic signed [ceb_pkg::IN_W-1:0]    sample_time,
  output int                                 pending,
  input  logic                               out_valid,
  input  logic                               out_stall,
  input  logic signed [ceb_pkg::VALUE_W-1:0] progress,
  input  logic                               time_clipped,
  output int                                 errors
);

  localparam int FB = ceb_pkg::FRACTION_BITS_DEF;
  localparam longint ONE_T = 64'd1 << FB;

  typedef struct packed {
    logic signed [15:0] value;
    logic               clipped;
  } ease_t;

  logic [15:0] x1, x2;
  logic signed [15:0] y1, y2;
  ease_t ease_q[$];

  function automatic void basis(input longint t, output longint uut, output longint utt,
                                output longint ttt);
    longint u, uu, tt;
    u = ONE_T - t;
    uu = (u * u) >>> FB;
    tt = (t * t) >>> FB;
    uut = (uu * t) >>> FB;
    utt = (u * tt) >>> FB;
    ttt = (tt * t) >>> FB;
  endfunction

  function automatic longint clamp_x(input logic [15:0] v);
    return (v > ceb_pkg::TIME_ONE) ? longint'(ceb_pkg::TIME_ONE) : longint'(v);
  endfunction

  function automatic ease_t ease(input logic signed [16:0] st);
    longint tm, t, lo, hi, mid, uut, utt, ttt, xv, y;
    ease_t r;
    r.clipped = 1'b0;
    tm = st;
    if (tm < 0) begin
      tm = 0;
      r.clipped = 1'b1;
    end else if (tm > 32768) begin
      tm = 32768;
      r.clipped = 1'b1;
    end
    if (tm == 0) t = 0;
    else if (tm == 32768) t = ONE_T;
    else begin
      lo = 0;
      hi = ONE_T;
      for (int i = 0; i < ceb_pkg::SOLVE_STEPS_DEF; i++) begin
        mid = (lo + hi) >>> 1;
        basis(mid, uut, utt, ttt);
        xv = 3 * uut * clamp_x(x1) + 3 * utt * clamp_x(x2) + (ttt <<< 15);
        if (xv < (tm <<< FB)) lo = mid;
        else hi = mid;
      end
      t = (lo + hi) >>> 1;
    end
    basis(t, uut, utt, ttt);
    y = 3 * uut * longint'(y1) + 3 * utt * longint'(y2) + (ttt <<< 14);
    y = (y + (64'sd1 <<< (FB - 1))) >>> FB;
    if (y > 32767) y = 32767;
    if (y < -32768) y = -32768;
    r.value = y[15:0];
    return r;
  endfunction

  assign pending = ease_q.size();

  always @(posedge clk) begin
    ease_t exp_r;
    if (rst) begin
      x1 <= ceb_pkg::RST_FIRST_X;
      y1 <= ceb_pkg::RST_FIRST_Y;
      x2 <= ceb_pkg::RST_SECOND_X;
      y2 <= ceb_pkg::RST_SECOND_Y;
      ease_q.delete();
      errors <= 0;
    end else begin
      if (cfg_wr_en) begin
        case (ceb_pkg::reg_idx_t'(cfg_index))
          ceb_pkg::REG_FIRST_X:  x1 <= cfg_data;
          ceb_pkg::REG_FIRST_Y:  y1 <= cfg_data;
          ceb_pkg::REG_SECOND_X: x2 <= cfg_data;
          ceb_pkg::REG_SECOND_Y: y2 <= cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) ease_q.push_back(ease(sample_time));
      if (out_valid && !out_stall) begin
        if (ease_q.size() == 0) begin
          $display("%0t: unexpected item progress=%0d clipped=%0b", $time,
                   progress, time_clipped);
          errors <= errors + 1;
        end else begin
          exp_r = ease_q.pop_front();
          if (exp_r.value !== progress || exp_r.clipped !== time_clipped) begin
            $display("%0t: mismatch expected progress=%0d clipped=%0b, actual %0d %0b",
                     $time, exp_r.value, exp_r.clipped, progress, time_clipped);
            errors <= errors + 1;
          end
        end
      end
    end
  end
endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// drives time samples into the easing pipeline under several control point
// settings with bursty input and random output stalls, and gives the verdict
// ----------------------------------------------------------------------------
module tb_top;

  localparam int LATENCY = 3 * ceb_pkg::SOLVE_STEPS_DEF + 4;
  localparam longint LIMIT = 400000;

  logic clk, rst, cfg_wr_en, in_valid, out_stall;
  logic [1:0] cfg_index;
  logic [15:0] cfg_data;
  logic signed [16:0] sample_time;
  logic in_stall, out_valid, time_clipped;
  logic signed [15:0] progress;
  int pending, errors;
  longint cycles = 0;
  bit stall_mode = 1'b1;

  cubic_bezier_easing_top DUT (.*);
  ceb_scoreboard u_checker (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // receiver stall pattern, with stretches of no stalling
  always @(posedge clk) begin
    if (rst) out_stall <= 0;
    else if ($urandom_range(0, 199) == 0) stall_mode <= ~stall_mode;
    else out_stall <= stall_mode ? ($urandom_range(0, 2) == 0) : 1'b0;
  end

  task automatic write_reg(input ceb_pkg::reg_idx_t idx, input logic [15:0] val);
    cfg_wr_en <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_wr_en <= 0;
  endtask

  task automatic send_time(input logic signed [16:0] tv);
    in_valid <= 1;
    sample_time <= tv;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic idle_gap();
    in_valid <= 0;
    repeat ($urandom_range(1, 6)) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic signed [16:0] rand_time();
    case ($urandom_range(0, 9))
      0: return 17'(-17'sd1 - $urandom_range(0, 32767));
      1: return 17'(17'sd32769 + $urandom_range(0, 32766));
      2: return $urandom_range(0, 1) ? 17'sd0 : 17'sd32768;
      3: return $urandom_range(0, 1) ? 17'sd1 : 17'sd32767;
      default: return 17'($urandom_range(0, 32768));
    endcase
  endfunction

  task automatic random_phase(input int n);
    int burst;
    while (n > 0) begin
      burst = $urandom_range(1, 40);
      for (int i = 0; i < burst && n > 0; i++, n--) send_time(rand_time());
      if ($urandom_range(0, 2) != 0) idle_gap();
    end
    drain();
  endtask

  logic signed [16:0] directed[] = '{17'sd0, 17'sd32768, -17'sd1, -17'sd65536, 17'sd32769,
      17'sd65535, 17'sd1, 17'sd32767, 17'sd16384, 17'sd8192, 17'sd24576, 17'sd100,
      17'sh0AAAA, 17'sh05555, 17'sh1FFFF, 17'sh10000};

  initial begin
    rst = 1;
    cfg_wr_en = 0;
    cfg_index = ceb_pkg::REG_FIRST_X;
    cfg_data = 0;
    in_valid = 0;
    sample_time = 0;
    repeat (10) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    foreach (directed[i]) send_time(directed[i]);
    drain();
    random_phase(300);
    // extreme x, extreme y including overshoot, then random control points
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin
          write_reg(ceb_pkg::REG_FIRST_X, 16'd0); write_reg(ceb_pkg::REG_FIRST_Y, 16'h7FFF);
          write_reg(ceb_pkg::REG_SECOND_X, 16'd32768);
          write_reg(ceb_pkg::REG_SECOND_Y, 16'h8000);
        end
        1: begin
          write_reg(ceb_pkg::REG_FIRST_X, 16'hFFFF); write_reg(ceb_pkg::REG_FIRST_Y, 16'h8000);
          write_reg(ceb_pkg::REG_SECOND_X, 16'd0);
          write_reg(ceb_pkg::REG_SECOND_Y, 16'h7FFF);
        end
        2: begin
          write_reg(ceb_pkg::REG_FIRST_X, 16'd32768);
          write_reg(ceb_pkg::REG_FIRST_Y, 16'h7FFF);
          write_reg(ceb_pkg::REG_SECOND_X, 16'd32768);
          write_reg(ceb_pkg::REG_SECOND_Y, 16'h7FFF);
        end
        default: begin
          write_reg(ceb_pkg::REG_FIRST_X, 16'($urandom));
          write_reg(ceb_pkg::REG_FIRST_Y, 16'($urandom));
          write_reg(ceb_pkg::REG_SECOND_X, 16'($urandom_range(0, 32768)));
          write_reg(ceb_pkg::REG_SECOND_Y, 16'($urandom));
        end
      endcase
      random_phase(200);
    end
    repeat (LATENCY + 10) @(posedge clk);
    if (errors == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end
endmodule
